FILE: sv/mlt_pkg.sv
// Shared constants, codes and word types of the MAC learning table.
package mlt_pkg;

  // Address, field and counter widths
  localparam int ADDR_BYTES = 6;
  localparam int MAC_W      = 8 * ADDR_BYTES;
  localparam int PORT_W     = 5;
  localparam int STAMP_W    = 16;
  localparam int TIMEOUT_W  = 15;
  localparam int COUNT_W    = 11;
  localparam int MODE_W     = 3;

  // Default geometry of the table
  localparam int DEF_BUCKETS = 256;
  localparam int DEF_WAYS    = 4;
  localparam int DEF_PORTS   = 32;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(300);

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LEARN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AGE    = 3'd4;

  // Input word
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } item_t;

  // Result word
  typedef struct packed {
    logic               hit;
    logic [PORT_W-1:0]  out_port;
    logic               status;
    logic [COUNT_W-1:0] removed_count;
  } result_t;

  // One way of a bucket row in the table memory
  typedef struct packed {
    logic               valid;
    logic [MAC_W-1:0]   mac;
    logic [PORT_W-1:0]  port;
    logic [STAMP_W-1:0] stamp;
  } way_t;

endpackage

FILE: sv/mac_learning_table_with_aging_top.sv
// MAC learning table with aging: bucket memory, read-modify-write control, age sweep.
//
// Usage:
//   Input words (mode, mac, port) arrive on in_valid/in_stall; each one gives
//   exactly one result word (hit, out_port, status, removed_count) on
//   out_valid/out_stall. Items are handled one at a time. For lookup, learn,
//   delete and tick the bucket row is read from the table memory on the accept
//   edge; in S_MOD the result is registered and a changed row written back. An
//   age sweep walks the memory one bucket row a cycle and holds at the last row
//   while the receiver stalls. The result sits in an output register, so the
//   next item is accepted while a result still waits. If the receiver stalls,
//   the block holds the finished item (no write back) until the output register
//   is free. timeout_limit is written through cfg_wr_en/cfg_wr_data; the user
//   must write it only while idle, which the block does not enforce. Reset (rst,
//   synchronous) empties the table at once through one valid flop per bucket
//   row, clears the tick counter and loads timeout 300. No clearing pass is
//   needed; the first item is taken the cycle after reset.
module mac_learning_table_with_aging_top
  import mlt_pkg::*;
#(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int WAYS    = DEF_WAYS,
  parameter int PORTS   = DEF_PORTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [TIMEOUT_W-1:0] cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  item_t                in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output result_t              out_data
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MOD   = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;

  // Table memory and per-row valid flops
  way_t [WAYS-1:0] mem [BUCKETS];
  logic [BUCKETS-1:0] row_ok;

  logic [1:0]           state;
  logic [1:0]           state_next;
  item_t                item_q;
  logic [BW-1:0]        bucket_q;
  logic [BW-1:0]        sweep_addr;
  logic [COUNT_W-1:0]   sweep_cnt;
  logic [STAMP_W-1:0]   now_ticks;
  logic [TIMEOUT_W-1:0] timeout_limit;

  logic                 rd_en;
  logic [BW-1:0]        rd_addr;
  way_t [WAYS-1:0]      rd_row;
  logic                 rv_q;
  logic                 wr_en;
  logic [BW-1:0]        wr_addr;
  way_t [WAYS-1:0]      wr_row;

  logic [7:0]           hash;
  logic [BW-1:0]        hash_lut [256];
  logic [BW-1:0]        bucket_in;

  logic [WAYS-1:0]      v_eff;
  logic [WAYS-1:0]      match;
  logic [WAYS-1:0]      aged;
  logic                 found;
  logic [WW-1:0]        hit_way;
  logic                 has_free;
  logic [WW-1:0]        free_way;
  logic [COUNT_W-1:0]   aged_cnt;
  logic                 sweep_last;
  logic                 go;
  logic                 load;
  logic                 learn_ok;
  result_t              res_next;

  // Bucket number: XOR of the address bytes, reduced by a constant table
  for (genvar g = 0; g < 256; g++) begin : g_lut
    assign hash_lut[g] = BW'(g % BUCKETS);
  end

  always_comb begin
    hash = '0;
    for (int i = 0; i < ADDR_BYTES; i++) begin
      hash = hash ^ in_data.mac[8*i +: 8];
    end
  end

  assign bucket_in = hash_lut[hash];

  // Way search over the row just read
  always_comb begin
    found    = 1'b0;
    hit_way  = '0;
    has_free = 1'b0;
    free_way = '0;
    aged_cnt = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      v_eff[w] = rv_q & rd_row[w].valid;
      match[w] = v_eff[w] && (rd_row[w].mac == item_q.mac);
      aged[w]  = v_eff[w] &&
                 ((now_ticks - rd_row[w].stamp) > {1'b0, timeout_limit});
      if (match[w]) begin
        found   = 1'b1;
        hit_way = WW'(w);
      end
      if (!v_eff[w]) begin
        has_free = 1'b1;
        free_way = WW'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      aged_cnt = aged_cnt + COUNT_W'(aged[w]);
    end
  end

  assign go         = !out_valid || !out_stall;
  assign sweep_last = (sweep_addr == BW'(BUCKETS - 1));
  assign learn_ok   = {2'b00, item_q.port} < 7'(PORTS);
  assign in_stall   = (state != S_IDLE);
  assign wr_addr    = (state == S_SWEEP) ? sweep_addr : bucket_q;

  // Control: read issue, modify, write back and result
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = bucket_in;
    wr_en      = 1'b0;
    load       = 1'b0;
    res_next   = '0;
    for (int w = 0; w < WAYS; w++) begin
      wr_row[w]       = rd_row[w];
      wr_row[w].valid = v_eff[w];
    end
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          rd_en = 1'b1;
          if (in_data.mode == MODE_AGE) begin
            rd_addr    = '0;
            state_next = S_SWEEP;
          end else begin
            state_next = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (go) begin
          load       = 1'b1;
          state_next = S_IDLE;
          unique case (item_q.mode)
            MODE_LOOKUP: begin
              if (found) begin
                res_next.hit      = 1'b1;
                res_next.out_port = rd_row[hit_way].port;
              end
            end
            MODE_LEARN: begin
              if (learn_ok) begin
                if (found) begin
                  wr_en                  = 1'b1;
                  wr_row[hit_way].stamp  = now_ticks;
                  res_next.hit           = 1'b1;
                end else if (has_free) begin
                  wr_en                  = 1'b1;
                  wr_row[free_way].valid = 1'b1;
                  wr_row[free_way].mac   = item_q.mac;
                  wr_row[free_way].port  = item_q.port;
                  wr_row[free_way].stamp = now_ticks;
                end else begin
                  res_next.status = 1'b1;
                end
              end
            end
            MODE_DELETE: begin
              if (found) begin
                wr_en                 = 1'b1;
                wr_row[hit_way].valid = 1'b0;
                res_next.hit          = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        for (int w = 0; w < WAYS; w++) begin
          wr_row[w].valid = v_eff[w] & ~aged[w];
        end
        if (!sweep_last) begin
          wr_en   = 1'b1;
          rd_en   = 1'b1;
          rd_addr = sweep_addr + BW'(1);
        end else if (go) begin
          wr_en                  = 1'b1;
          load                   = 1'b1;
          res_next.removed_count = sweep_cnt + aged_cnt;
          state_next             = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

  // Control state, row valid flops, tick counter and timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      row_ok        <= '0;
      rv_q          <= 1'b0;
      now_ticks     <= '0;
      timeout_limit <= TIMEOUT_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        timeout_limit <= cfg_wr_data;
      end
      if (rd_en) begin
        rv_q <= row_ok[rd_addr];
      end
      if (wr_en) begin
        row_ok[wr_addr] <= 1'b1;
      end
      if (load && state == S_MOD && item_q.mode == MODE_TICK) begin
        now_ticks <= now_ticks + STAMP_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item_q     <= in_data;
      bucket_q   <= bucket_in;
      sweep_addr <= '0;
      sweep_cnt  <= '0;
    end else if (state == S_SWEEP && !sweep_last) begin
      sweep_addr <= sweep_addr + BW'(1);
      sweep_cnt  <= sweep_cnt + aged_cnt;
    end
    if (load) begin
      out_data <= res_next;
    end
  end

  // A row is never read and written in the same cycle
  a_no_rw_same_row: assert property (@(posedge clk) disable iff (rst)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("read and write of the same bucket row");

  // A result is only loaded when the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> !(out_valid && out_stall))
    else $error("result overwrote a pending word");

  // An accepted age sweep starts at the first row with a clear count
  a_sweep_start: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && in_valid && in_data.mode == MODE_AGE
    |=> state == S_SWEEP && sweep_addr == '0 && sweep_cnt == '0)
    else $error("age sweep did not start at row zero");

  // Full-bucket status only comes from a learn
  a_status_learn: assert property (@(posedge clk) disable iff (rst)
    load && res_next.status |-> item_q.mode == MODE_LEARN && state == S_MOD)
    else $error("status raised outside a learn");

endmodule
